// ===== rtl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

    // Fixed field widths
    localparam int IDX_W     = 10;
    localparam int ADDR_W    = 48;
    localparam int COUNT_W   = 11;
    localparam int STRIDE_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 2'd2;

    // Register reset values
    localparam logic [COUNT_W-1:0]  SLOT_COUNT_RST  = 11'd1024;
    localparam logic [ADDR_W-1:0]   HEAP_BASE_RST   = 48'd0;
    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 16'd32;

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic update;
        logic mult;
        logic finish;
    } bsa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
    } bsa_sts_t;

endpackage

// ===== rtl/bsa_ctrl.sv =====
// Sequencing state machine of the bitmap slot allocator.
module bsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bsa_pkg::bsa_sts_t sts,
    output bsa_pkg::bsa_cmd_t cmd,
    output logic              busy
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_MULT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Work out the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: state_next = S_MULT;
            S_MULT:   state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold state and the registered busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    // Decode commands from the state and, for accept, from start and the busy flag
    always_comb
    begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.accept   = start && !busy_reg;
        cmd.update   = (state_reg == S_UPDATE);
        cmd.mult     = (state_reg == S_MULT);
        cmd.finish   = (state_reg == S_FINISH);
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/bsa_datapath.sv =====
// Free bitmap memory, group summary and result datapath of the slot allocator.
module bsa_datapath
#(
    parameter int MAX_SLOTS  = 1024,
    parameter int GROUP_BITS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsa_pkg::bsa_cmd_t              cmd,
    output bsa_pkg::bsa_sts_t              sts,
    input  logic                           action,
    input  logic [bsa_pkg::IDX_W-1:0]      slot_to_free,
    input  logic [bsa_pkg::COUNT_W-1:0]    slot_count,
    input  logic [bsa_pkg::ADDR_W-1:0]     heap_base,
    input  logic [bsa_pkg::STRIDE_W-1:0]   slot_stride,
    output logic                           done,
    output logic [bsa_pkg::STATUS_W-1:0]   status,
    output logic [bsa_pkg::IDX_W-1:0]      slot_index,
    output logic [bsa_pkg::ADDR_W-1:0]     slot_address
);
    import bsa_pkg::*;

    localparam int NGROUPS  = (MAX_SLOTS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GRP_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int BIT_W    = $clog2(GROUP_BITS);
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (1 << RECIP_SH) / GROUP_BITS;
    localparam int QP_W     = IDX_W + RECIP_SH;
    localparam int PROD_W   = SLOT_W + STRIDE_W;

    // Free bitmap, one word per group; a set bit marks a free slot
    logic [GROUP_BITS-1:0] free_mem [NGROUPS];
    logic [GROUP_BITS-1:0] rd_data_reg;

    logic [NGROUPS-1:0]    nonempty_reg;
    logic [GRP_W-1:0]      clr_cnt_reg;

    // Request captured at accept
    logic                  act_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [SLOT_W-1:0]     grp_slot_reg;
    logic [BIT_W-1:0]      free_bit_reg;
    logic                  found_reg;
    logic                  bad_reg;

    // Update and multiply stage registers
    logic [STATUS_W-1:0]   stat_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  addr_en_reg;
    logic [PROD_W-1:0]     prod_reg;

    // Output registers
    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [IDX_W-1:0]      slot_index_reg;
    logic [ADDR_W-1:0]     slot_address_reg;

    logic [CNT_W-1:0]      eff_count;
    logic [GRP_W-1:0]      pick_grp;
    logic                  any_grp;
    logic [QP_W-1:0]       free_prod;
    logic [IDX_W-1:0]      q_est;
    logic [IDX_W-1:0]      q_mul;
    logic [IDX_W-1:0]      rem_raw;
    logic [IDX_W-1:0]      free_q;
    logic [IDX_W-1:0]      free_rem;
    logic [GRP_W-1:0]      rd_addr;
    logic [CNT_W:0]        lim;
    logic [GROUP_BITS-1:0] elig;
    logic [GROUP_BITS-1:0] word;
    logic [BIT_W-1:0]      low_bit;
    logic                  hit;
    logic [GROUP_BITS-1:0] alloc_word;
    logic [GROUP_BITS-1:0] free_word;
    logic                  wr_en;
    logic [GROUP_BITS-1:0] wr_data;
    logic [SLOT_W-1:0]     alloc_slot;

    // Clamp the slot count to the built capacity
    always_comb
    begin
        if (32'(slot_count) > 32'(MAX_SLOTS))
        begin
            eff_count = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            eff_count = CNT_W'(slot_count);
        end
    end

    // Pick the lowest group that still has a free bit
    always_comb
    begin
        pick_grp = '0;
        any_grp  = |nonempty_reg;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (nonempty_reg[g])
            begin
                pick_grp = GRP_W'(g);
            end
        end
    end

    // Split the freed index into group and bit by reciprocal multiply
    always_comb
    begin
        free_prod = QP_W'(slot_to_free) * QP_W'(RECIP);
        q_est     = free_prod[QP_W-1:RECIP_SH];
        q_mul     = IDX_W'(q_est * GROUP_BITS);
        rem_raw   = slot_to_free - q_mul;
        if (rem_raw >= IDX_W'(GROUP_BITS))
        begin
            free_q   = q_est + 1'b1;
            free_rem = rem_raw - IDX_W'(GROUP_BITS);
        end
        else
        begin
            free_q   = q_est;
            free_rem = rem_raw;
        end
        rd_addr = (action == ACT_ALLOC) ? pick_grp : GRP_W'(free_q);
    end

    // Mask off slots at or above the count, then find the lowest free bit
    always_comb
    begin
        lim = {1'b0, eff_count} - (CNT_W + 1)'(grp_slot_reg);
        if (lim[CNT_W])
        begin
            elig = '0;
        end
        else if (lim >= (CNT_W + 1)'(GROUP_BITS))
        begin
            elig = '1;
        end
        else
        begin
            elig = (GROUP_BITS'(1) << lim[BIT_W-1:0]) - GROUP_BITS'(1);
        end

        word    = rd_data_reg & elig;
        hit     = found_reg && (word != '0);
        low_bit = '0;
        for (int i = GROUP_BITS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                low_bit = BIT_W'(i);
            end
        end

        alloc_word = rd_data_reg & ~(GROUP_BITS'(1) << low_bit);
        free_word  = rd_data_reg | (GROUP_BITS'(1) << free_bit_reg);
        alloc_slot = grp_slot_reg + SLOT_W'(low_bit);

        if (act_reg == ACT_ALLOC)
        begin
            wr_en   = cmd.update && hit;
            wr_data = alloc_word;
        end
        else
        begin
            wr_en   = cmd.update && !bad_reg;
            wr_data = free_word;
        end
    end

    // Sweep the bitmap to all free after reset
    assign sts.clear_last = (clr_cnt_reg == GRP_W'(NGROUPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr && !sts.clear_last)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Bitmap memory: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            free_mem[clr_cnt_reg] <= '1;
        end
        else if (wr_en)
        begin
            free_mem[grp_reg] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= free_mem[rd_addr];
        end
    end

    // Keep the per-group summary in step with the bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '1;
        end
        else if (wr_en)
        begin
            nonempty_reg[grp_reg] <= (wr_data != '0);
        end
    end

    // Capture the request word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg      <= action;
            idx_reg      <= slot_to_free;
            grp_reg      <= rd_addr;
            grp_slot_reg <= SLOT_W'(pick_grp * GROUP_BITS);
            free_bit_reg <= BIT_W'(free_rem);
            found_reg    <= any_grp;
            bad_reg      <= (32'(slot_to_free) >= 32'(eff_count));
        end
    end

    // Form status and index; then the slot offset product
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            slot_reg <= alloc_slot;
            if (act_reg == ACT_ALLOC)
            begin
                stat_reg    <= hit ? STATUS_OK : STATUS_FULL;
                index_reg   <= hit ? IDX_W'(alloc_slot) : '0;
                addr_en_reg <= hit;
            end
            else
            begin
                stat_reg    <= bad_reg ? STATUS_BAD_INDEX : STATUS_OK;
                index_reg   <= idx_reg;
                addr_en_reg <= 1'b0;
            end
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(slot_reg) * PROD_W'(slot_stride);
        end
    end

    // Register done from finish, and the result word when finish is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg     <= stat_reg;
            slot_index_reg <= index_reg;
            if (addr_en_reg)
            begin
                slot_address_reg <= ADDR_W'(heap_base + ADDR_W'(prod_reg));
            end
            else
            begin
                slot_address_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_index   = slot_index_reg;
    assign slot_address = slot_address_reg;

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: configuration registers and wiring.
//
// First-fit slot allocator over a free bitmap. Pulse start while busy is low
// to hand in one word: action selects allocate (lowest free slot below
// slot_count) or free (slot_to_free). Each word passes the bitmap memory
// read, the read-modify-write of one group word and the registered stride
// multiply ahead of the address add; a new word is taken only once the last
// one is through. The result is shown for exactly one cycle with done high;
// the receiver cannot stall it and must take it then. After reset busy
// stays high while the bitmap is swept to all free, one group word at a
// time (MAX_SLOTS / GROUP_BITS words, rounded up: 16 at the defaults).
// Configuration writes are taken at any time but must only be made while
// the block is idle.
module bitmap_slot_allocator
#(
    parameter int MAX_SLOTS  = 1024,
    parameter int GROUP_BITS = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bsa_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [bsa_pkg::IDX_W-1:0]        slot_to_free,
    output logic                             done,
    output logic [bsa_pkg::STATUS_W-1:0]     status,
    output logic [bsa_pkg::IDX_W-1:0]        slot_index,
    output logic [bsa_pkg::ADDR_W-1:0]       slot_address
);
    import bsa_pkg::*;

    logic [COUNT_W-1:0]  slot_count_reg;
    logic [ADDR_W-1:0]   heap_base_reg;
    logic [STRIDE_W-1:0] slot_stride_reg;

    bsa_cmd_t cmd;
    bsa_sts_t sts;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= SLOT_COUNT_RST;
            heap_base_reg   <= HEAP_BASE_RST;
            slot_stride_reg <= SLOT_STRIDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SLOT_COUNT:  slot_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_HEAP_BASE:   heap_base_reg   <= cfg_data;
                CFG_SLOT_STRIDE: slot_stride_reg <= cfg_data[STRIDE_W-1:0];
                default:         ;
            endcase
        end
    end

    bsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bsa_datapath
    #(
        .MAX_SLOTS  (MAX_SLOTS),
        .GROUP_BITS (GROUP_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .slot_to_free (slot_to_free),
        .slot_count   (slot_count_reg),
        .heap_base    (heap_base_reg),
        .slot_stride  (slot_stride_reg),
        .done         (done),
        .status       (status),
        .slot_index   (slot_index),
        .slot_address (slot_address)
    );

`ifndef SYNTHESIS
    // An accepted word keeps the block busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // Every accepted word yields its result strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe missing after accepted word");

    // Results never come in adjacent cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A failed request must return a zero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (slot_address == '0))
        else $error("failed request returned a nonzero address");
`endif

endmodule
